// ===== hw/rtl/rmsd_pkg.sv =====
package rmsd_pkg;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] mean_out;
        logic        [31:0] std_dev;
        logic        [23:0] sample_total;
        logic               overflow;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MDIV,
        S_MUPD,
        S_MUL,
        S_ACC,
        S_VLOAD,
        S_VDIV,
        S_SINIT,
        S_SQRT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic sample_load;
        logic div_step;
        logic mean_upd;
        logic mul_step;
        logic sum_acc;
        logic var_load;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic count_ge2;
    } stat_t;

    localparam int MEAN_DIV_STEPS = 49;
    localparam int VAR_DIV_STEPS  = 64;
    localparam int MUL_STEPS      = 34;
    localparam int SQRT_STEPS     = 32;

    // magnitude of floor(v / 2^16)
    function automatic logic [33:0] floor16_mag(input logic signed [48:0] v);
        logic [49:0] m;
        logic [49:0] t;
        begin
            m = {1'b0, (~v) + 49'd1};
            t = m + 50'd65535;
            if (v[48])
            begin
                floor16_mag = t[49:16];
            end
            else
            begin
                floor16_mag = {1'b0, v[48:16]};
            end
        end
    endfunction

endpackage

// ===== hw/rtl/rmsd_ctrl.sv =====
module rmsd_ctrl
    import rmsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sample_valid,
    output logic  sample_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [6:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;
    logic       loop_state;
    logic       done;

    assign slot_free = !out_valid_reg || result_ready;
    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    assign loop_state = (state_reg == S_MDIV) || (state_reg == S_MUL)
                     || (state_reg == S_VDIV) || (state_reg == S_SQRT);

    always_comb
    begin
        case (state_reg)
            S_MDIV:  done = (step_reg == 7'(MEAN_DIV_STEPS - 1));
            S_MUL:   done = (step_reg == 7'(MUL_STEPS - 1));
            S_VDIV:  done = (step_reg == 7'(VAR_DIV_STEPS - 1));
            S_SQRT:  done = (step_reg == 7'(SQRT_STEPS - 1));
            default: done = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = (loop_state && !done) ? step_reg + 7'd1 : 7'd0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (sample_valid) state_next = S_MDIV;
            S_MDIV:  if (done) state_next = S_MUPD;
            S_MUPD:  state_next = S_MUL;
            S_MUL:   if (done) state_next = S_ACC;
            S_ACC:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (stat.count_ge2)
                    state_next = S_VLOAD;
                else
                    state_next = S_FIN;
            end
            S_VLOAD: state_next = S_VDIV;
            S_VDIV:  if (done) state_next = S_SINIT;
            S_SINIT: state_next = S_SQRT;
            S_SQRT:  if (done) state_next = S_FIN;
            S_FIN:   if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.sample_load = sample_valid;
            S_MDIV:  cmd.div_step = 1'b1;
            S_MUPD:  cmd.mean_upd = 1'b1;
            S_MUL:   cmd.mul_step = 1'b1;
            S_ACC:   cmd.sum_acc = 1'b1;
            S_VLOAD: cmd.var_load = 1'b1;
            S_VDIV:  cmd.div_step = 1'b1;
            S_SINIT: cmd.sqrt_init = 1'b1;
            S_SQRT:  cmd.sqrt_step = 1'b1;
            S_FIN:   cmd.out_load = slot_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten while stalled");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> (state_reg == S_MDIV && step_reg == 7'd0))
        else $error("accepted transaction did not start the divider");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 7'(VAR_DIV_STEPS - 1))
        else $error("step counter out of range");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== hw/rtl/rmsd_dp.sv =====
module rmsd_dp
    import rmsd_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    input  in_t  sample_data,
    input  cmd_t cmd,
    output stat_t stat,
    output out_t result_data
);

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    logic signed [47:0]    mean_reg, mean_next;
    logic [63:0]           sum_reg, sum_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  sat_reg, sat_next;
    logic                  last_reg;
    logic                  neg_reg;
    logic signed [48:0]    x48_reg;
    logic [67:0]           mcand_reg;
    logic [33:0]           mplier_reg;
    logic [67:0]           acc_reg;
    logic [63:0]           rq_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [63:0]           sq_v_reg;
    logic [63:0]           sq_res_reg;
    logic [63:0]           sq_bit_reg;
    out_t                  out_reg;

    logic signed [48:0]    x48_in;
    logic signed [48:0]    d1;
    logic [48:0]           d1_mag;
    logic [COUNT_BITS-1:0] n_new;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  q_bit;
    logic [48:0]           q_mag;
    logic [48:0]           q_s;
    logic signed [47:0]    mean_upd;
    logic signed [48:0]    d2;
    logic [63:0]           prod_sat;
    logic [64:0]           sum_wide;
    logic [63:0]           sq_try;
    logic [COUNT_BITS+23:0] cnt_ext;

    assign stat.last      = last_reg;
    assign stat.count_ge2 = (cnt_reg >= COUNT_BITS'(2));
    assign result_data    = out_reg;

    always_comb
    begin
        x48_in = {sample_data.sample[31], sample_data.sample, 16'h0000};
        d1     = x48_in - {mean_reg[47], mean_reg};
        d1_mag = d1[48] ? (~d1) + 49'd1 : d1;
        n_new  = (cnt_reg == CountMax) ? CountMax : cnt_reg + COUNT_BITS'(1);

        rem_sh = {rem_reg, rq_reg[63]};
        q_bit  = (rem_sh >= {1'b0, dvs_reg});

        q_mag    = rq_reg[48:0];
        q_s      = neg_reg ? (~q_mag) + 49'd1 : q_mag;
        mean_upd = mean_reg + q_s[47:0];
        d2       = x48_reg - {mean_upd[47], mean_upd};

        prod_sat = (|acc_reg[67:64]) ? {64{1'b1}} : acc_reg[63:0];
        sum_wide = {1'b0, sum_reg} + {1'b0, prod_sat};

        sq_try  = sq_res_reg + sq_bit_reg;
        cnt_ext = {24'd0, cnt_reg};
    end

    // running state, cleared when each result is loaded into the output register
    always_comb
    begin
        mean_next = mean_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        if (cmd.sample_load)
        begin
            cnt_next = n_new;
            if (cnt_reg == CountMax)
                sat_next = 1'b1;
        end
        if (cmd.mean_upd)
            mean_next = mean_upd;
        if (cmd.sum_acc)
            sum_next = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
        if (cmd.out_load)
        begin
            mean_next = '0;
            sum_next  = '0;
            cnt_next  = '0;
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            mean_reg <= mean_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            sat_reg  <= sat_next;
        end
    end

    // shared restoring divider, multiplier, square root
    always_ff @(posedge clk)
    begin
        if (cmd.sample_load)
        begin
            last_reg  <= sample_data.last;
            neg_reg   <= d1[48];
            x48_reg   <= x48_in;
            mcand_reg <= {34'd0, floor16_mag(d1)};
            rq_reg    <= {d1_mag, 15'd0};
            rem_reg   <= '0;
            dvs_reg   <= n_new;
        end
        if (cmd.var_load)
        begin
            rq_reg  <= sum_reg;
            rem_reg <= '0;
            dvs_reg <= cnt_reg - COUNT_BITS'(1);
        end
        if (cmd.div_step)
        begin
            rq_reg  <= {rq_reg[62:0], q_bit};
            rem_reg <= q_bit ? rem_sh[COUNT_BITS-1:0] - dvs_reg : rem_sh[COUNT_BITS-1:0];
        end
        if (cmd.mean_upd)
        begin
            mplier_reg <= floor16_mag(d2);
            acc_reg    <= '0;
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[66:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[33:1]};
        end
        if (cmd.sqrt_init)
        begin
            sq_v_reg   <= rq_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        if (cmd.sqrt_step)
        begin
            if (sq_v_reg >= sq_try)
            begin
                sq_v_reg   <= sq_v_reg - sq_try;
                sq_res_reg <= {1'b0, sq_res_reg[63:1]} + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= {1'b0, sq_res_reg[63:1]};
            end
            sq_bit_reg <= {2'b00, sq_bit_reg[63:2]};
        end
        if (cmd.out_load)
        begin
            out_reg.mean_out     <= mean_reg[47:16];
            out_reg.std_dev      <= (cnt_reg >= COUNT_BITS'(2)) ? sq_res_reg[31:0] : 32'd0;
            out_reg.sample_total <= cnt_ext[23:0];
            out_reg.overflow     <= sat_reg;
        end
    end

endmodule

// ===== hw/rtl/running_mean_std_dev.sv =====
// Running mean and sample standard deviation over sets of Q16.16 samples.
// Input channel sample_*: one transaction per sample; last closes the set.
// Output channel result_*: one transaction per set, carrying the floored
// mean, the floor square root of sum / (count - 1) (zero below two
// samples), the saturated count and the overflow flag.
// Each sample runs 49 divider steps for the mean update, 34 multiplier
// steps for the squared deviation, and the accept, mean-update and
// accumulate steps before the next sample is accepted. When count >= 2,
// a sample marked last adds a load and 64 divider steps, a load and 32
// square-root steps, and a step that loads the result register.
// The rate is set by the single shift-subtract divider and the serial
// shift-add multiplier, one bit per cycle each.
// After reset the statistics are zero and the block is ready at once.
// The result sits in an output register; while the receiver stalls the
// next set is still accumulated, and only its result waits for the slot.
module running_mean_std_dev
    import rmsd_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic sample_valid,
    output logic sample_ready,
    input  in_t  sample_data,
    output logic result_valid,
    input  logic result_ready,
    output out_t result_data
);

    cmd_t  cmd;
    stat_t stat;

    rmsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    rmsd_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_data (sample_data),
        .cmd         (cmd),
        .stat        (stat),
        .result_data (result_data)
    );

endmodule

// ===== dv/running_mean_std_dev_tb.sv =====
module running_mean_std_dev_tb;
    import rmsd_pkg::*;

    localparam int  CNT_W     = 24;
    localparam int  WDOG_MAX  = 20000;
    localparam int  N_RANDOM  = 1800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    in_t  sample_data = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_t result_data;

    int  n_errors = 0;
    bit  quiet_phase = 1'b0;
    int  idle_cycles = 0;

    always #4 clk = ~clk;

    running_mean_std_dev #(.COUNT_BITS(CNT_W)) i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    task automatic report(input string what, input longint got, input longint want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    class stats_scoreboard;
        logic signed [47:0] mean_acc;
        logic        [63:0] sq_dev_sum;
        logic [CNT_W-1:0]   n_seen;
        bit                 saturated;
        out_t               pending[$];

        function void clear();
            mean_acc   = '0;
            sq_dev_sum = '0;
            n_seen     = '0;
            saturated  = 1'b0;
        endfunction

        function logic [33:0] flr_mag(input logic signed [63:0] v);
            logic [63:0] m;
            if (v < 0)
            begin
                m = -v;
                return 34'((m + 64'd65535) >> 16);
            end
            return 34'(v >>> 16);
        endfunction

        function logic [63:0] root(input logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void note_sample(input in_t t);
            logic signed [63:0]  x, d1, d2, mean_w, q;
            logic        [63:0]  a, b, var_q, sd;
            logic        [127:0] prod;
            logic        [64:0]  total;
            logic        [63:0]  nn;
            out_t r;
            if (n_seen == {CNT_W{1'b1}})
                saturated = 1'b1;
            else
                n_seen++;
            nn = 64'(n_seen);
            x = 64'(t.sample) * 65536;
            mean_w = 64'(mean_acc);
            d1 = x - mean_w;
            q = d1 / $signed(nn);
            mean_w = mean_w + q;
            mean_acc = mean_w[47:0];
            d2 = x - mean_w;
            a = 64'(flr_mag(d1));
            b = 64'(flr_mag(d2));
            prod = a * b;
            if (prod[127:64] != 0)
                prod = {64'd0, {64{1'b1}}};
            total = {1'b0, sq_dev_sum} + {1'b0, prod[63:0]};
            sq_dev_sum = total[64] ? {64{1'b1}} : total[63:0];
            if (!t.last)
                return;
            sd = 0;
            if (n_seen >= 2)
            begin
                var_q = sq_dev_sum / (nn - 1);
                sd = root(var_q);
            end
            r.mean_out     = 32'(mean_w >>> 16);
            r.std_dev      = sd[31:0];
            r.sample_total = 24'(n_seen);
            r.overflow     = saturated;
            pending = {pending, r};
            clear();
        endfunction

        task check_result(input out_t got);
            out_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.mean_out !== w.mean_out)
                report("mean_out", longint'(got.mean_out), longint'(w.mean_out));
            if (got.std_dev !== w.std_dev)
                report("std_dev", longint'(got.std_dev), longint'(w.std_dev));
            if (got.sample_total !== w.sample_total)
                report("sample_total", longint'(got.sample_total),
                       longint'(w.sample_total));
            if (got.overflow !== w.overflow)
                report("overflow", longint'(got.overflow), longint'(w.overflow));
        endtask
    endclass

    stats_scoreboard sb = new();

    task automatic push_sample(input logic signed [31:0] s, input bit lst);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= '{sample: s, last: lst};
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        sb.note_sample('{sample: s, last: lst});
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 200000)) - 32'd100000);
            default: return $signed($urandom());
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result_data);
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : ready_gen
        int burst;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 9);
                result_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stim
        int len;
        int done;
        sb.clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single sample, two samples, extremes, three-sample sets, alternating extremes
        push_sample(32'sh0001_0000, 1'b1);
        push_sample(32'sh7FFF_FFFF, 1'b0);
        push_sample(32'sh8000_0000, 1'b1);
        push_sample(32'sh8000_0000, 1'b1);
        push_sample(32'sh7FFF_FFFF, 1'b1);
        push_sample(32'sh0000_0000, 1'b0);
        push_sample(32'sh0000_0000, 1'b1);
        push_sample(-32'sh0000_0001, 1'b0);
        push_sample(32'sh0000_0001, 1'b0);
        push_sample(-32'sh0003_8000, 1'b1);
        for (int i = 0; i < 8; i++)
            push_sample(i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000, i == 7);
        push_sample(32'shFFFF_FFFF, 1'b0);
        push_sample(32'sh5555_AAAA, 1'b0);
        push_sample(32'shAAAA_5555, 1'b1);

        done = 0;
        while (done < N_RANDOM)
        begin
            if (done > N_RANDOM * 9 / 10)
                quiet_phase = 1'b1;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                push_sample(rand_sample(), k == len - 1);
            done += len;
        end
        sample_valid <= 1'b0;

        len = 0;
        while (sb.pending.size() != 0 && len < 100000)
        begin
            @(posedge clk);
            len++;
        end
        repeat (300) @(posedge clk);
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
